@@ hdl/rtss_pkg.sv @@
package rtss_pkg;

  // Scheduler phases
  typedef enum logic [1:0] {
    PH_HOST  = 2'd0,
    PH_SCAN  = 2'd1,
    PH_DWELL = 2'd2
  } phase_e;

  // Radio commands
  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_ENTER = 2'd1,
    CMD_LEAVE = 2'd2
  } cmd_e;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 4;
  typedef enum logic [CfgIdxW-1:0] {
    CFG_ENABLED      = 4'd0,
    CFG_HOLD_OVR     = 4'd1,
    CFG_HOLD_FLOOR   = 4'd2,
    CFG_BLIND_BUDGET = 4'd3,
    CFG_DWELL        = 4'd4,
    CFG_MAX_DWELL    = 4'd5,
    CFG_TX_YIELD     = 4'd6,
    CFG_RETRY        = 4'd7
  } cfg_idx_e;

  localparam logic [15:0] MinHoldMs     = 16'd20;
  localparam logic [31:0] MaxExcessMs   = 32'd500;
  localparam logic [8:0]  DriftLimitMs  = 9'd5;

  // Input word
  typedef struct packed {
    logic [31:0] now_ms;
    logic        host_tx_pending;
    logic        host_busy;
    logic        guest_tx_pending;
    logic        guest_tx_busy;
    logic        guest_receiving;
    logic        guest_packet_in_progress;
    logic        channel_active;
  } in_t;

  // Result word
  typedef struct packed {
    logic [15:0] next_wait_ms;
    logic [1:0]  radio_command;
    logic        pump_request;
    logic [1:0]  slice_state;
    logic        dwell_timed_out;
    logic [8:0]  overhead_estimate_ms;
  } out_t;

  // Configuration write word
  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [15:0]        wdata;
  } cfg_t;

endpackage

@@ hdl/rtss_if.sv @@
// Tick input channel
interface rtss_in_if;
  logic          valid;
  logic          ready;
  rtss_pkg::in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// Result channel
interface rtss_out_if;
  logic           valid;
  logic           ready;
  rtss_pkg::out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// Configuration write channel
interface rtss_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rtss_pkg::CfgIdxW-1:0]    index;
  logic [15:0]                     wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

@@ hdl/radio_time_slice_scheduler.sv @@
// An accepted tick word reaches its result word through the input register and then the result register.
// Throughput: one tick word per cycle unless the result side stalls; the scheduler state is updated as a
// word moves from the input register into the result register, so the next word sees it without a bubble.
// Configuration writes are always taken, ready is always high.
// Reset (rst_ni low, asynchronous): phase host hold, all timers and estimates zero, registers at
// their defaults; both pipeline stages empty.
module radio_time_slice_scheduler #(
  parameter int unsigned PUMP_INTERVAL_MS = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rtss_in_if.sink    in_i,
  rtss_out_if.source out_o,
  rtss_cfg_if.sink   cfg_i
);

  localparam logic [15:0] PumpWait = 16'(PUMP_INTERVAL_MS);

  // Configuration registers
  logic        enabled_q;
  logic [15:0] hold_ovr_q, hold_floor_q, blind_budget_q, dwell_q, max_dwell_q, retry_q;
  logic [12:0] tx_yield_q;

  // Scheduler state
  rtss_pkg::phase_e phase_q, phase_d;
  logic        started_q;
  logic [31:0] phase_entered_q, phase_entered_d;
  logic        yield_waiting_q, yield_waiting_d;
  logic [31:0] yield_started_q, yield_started_d;
  logic [31:0] dwell_started_q, dwell_started_d;
  logic        cycle_ext_q, cycle_ext_d;
  logic        slice_seen_q, slice_seen_d;
  logic [31:0] last_slice_q, last_slice_d;
  logic [8:0]  ovh_q, ovh_d;
  logic [8:0]  derived_q, derived_d;

  // Pipeline stages
  logic            in_valid_q, out_valid_q;
  rtss_pkg::in_t   in_q;
  rtss_pkg::out_t  out_q, out_d;
  logic            adv;

  assign adv         = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || adv;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;
  assign cfg_i.ready = 1'b1;

  // Hold time from config and the derived overhead
  logic [15:0] hold_auto, hold;
  always_comb begin
    hold_auto = (blind_budget_q > {7'd0, derived_q}) ? blind_budget_q - {7'd0, derived_q}
                                                     : 16'd0;
    if (hold_auto < hold_floor_q) hold_auto = hold_floor_q;
    if (hold_auto < rtss_pkg::MinHoldMs) hold_auto = rtss_pkg::MinHoldMs;
    hold = (hold_ovr_q != 16'd0) ? hold_ovr_q : hold_auto;
  end

  // Host phase timing
  logic [31:0] now, pe_eff, held, yield_eff, yield_age;
  logic        held_short, in_budget;
  assign now        = in_q.now_ms;
  assign pe_eff     = started_q ? phase_entered_q : now;
  assign held       = now - pe_eff;
  assign held_short = held < {16'd0, hold};
  assign yield_eff  = yield_waiting_q ? yield_started_q : now;
  assign yield_age  = now - yield_eff;
  assign in_budget  = yield_age < {19'd0, tx_yield_q};

  // Decision flags for the current word
  logic scan_stay, dwell_busy, dwell_to, dwell_stay;
  logic host_on, host_hold, host_tx_yield, host_busy_wait, host_enter;
  always_comb begin
    scan_stay  = in_q.guest_receiving || in_q.guest_packet_in_progress ||
                 in_q.channel_active || in_q.guest_tx_pending || in_q.guest_tx_busy;
    dwell_busy = in_q.guest_receiving || in_q.guest_packet_in_progress ||
                 in_q.guest_tx_busy || in_q.guest_tx_pending;
    dwell_to   = dwell_busy && ((now - dwell_started_q) >= {16'd0, max_dwell_q});
    dwell_stay = dwell_busy && !dwell_to;
    host_on        = enabled_q && !held_short;
    host_hold      = enabled_q && held_short;
    host_tx_yield  = host_on && in_q.host_tx_pending && in_budget;
    host_busy_wait = host_on && !host_tx_yield && in_q.host_busy;
    host_enter     = host_on && !host_tx_yield && !in_q.host_busy;
  end

  // Overhead sample at slice start
  logic [16:0] expected;
  logic [31:0] cycle, excess;
  logic [10:0] ovh_sum;
  logic [8:0]  ovh_new, drift;
  always_comb begin
    expected = {1'b0, hold} + {1'b0, dwell_q};
    cycle    = now - last_slice_q;
    excess   = (cycle > {15'd0, expected}) ? cycle - {15'd0, expected} : 32'd0;
    ovh_sum  = {1'b0, ovh_q, 1'b0} + {2'd0, ovh_q} + excess[10:0];
    ovh_new  = ovh_q;
    if (slice_seen_q && !cycle_ext_q && excess <= rtss_pkg::MaxExcessMs) begin
      ovh_new = ovh_sum[10:2];
    end
    drift = (ovh_new > derived_q) ? ovh_new - derived_q : derived_q - ovh_new;
  end

  // Next state
  always_comb begin
    phase_d         = phase_q;
    phase_entered_d = pe_eff;
    yield_waiting_d = yield_waiting_q;
    yield_started_d = yield_started_q;
    dwell_started_d = dwell_started_q;
    cycle_ext_d     = cycle_ext_q;
    slice_seen_d    = slice_seen_q;
    last_slice_d    = last_slice_q;
    ovh_d           = ovh_q;
    derived_d       = derived_q;
    unique case (phase_q)
      rtss_pkg::PH_SCAN: begin
        phase_entered_d = now;
        if (scan_stay) begin
          phase_d         = rtss_pkg::PH_DWELL;
          cycle_ext_d     = 1'b1;
          dwell_started_d = now;
        end else begin
          phase_d = rtss_pkg::PH_HOST;
        end
      end
      rtss_pkg::PH_DWELL: begin
        if (!dwell_stay) begin
          phase_d         = rtss_pkg::PH_HOST;
          phase_entered_d = now;
        end
      end
      default: begin
        if (host_on) begin
          if (in_q.host_tx_pending) begin
            yield_waiting_d = 1'b1;
            yield_started_d = yield_eff;
          end else begin
            yield_waiting_d = 1'b0;
          end
        end
        if (host_enter) begin
          ovh_d           = ovh_new;
          last_slice_d    = now;
          slice_seen_d    = 1'b1;
          cycle_ext_d     = 1'b0;
          if (drift >= rtss_pkg::DriftLimitMs) derived_d = ovh_new;
          phase_d         = rtss_pkg::PH_SCAN;
          phase_entered_d = now;
        end
      end
    endcase
  end

  // Result word
  always_comb begin
    out_d.next_wait_ms         = hold;
    out_d.radio_command        = rtss_pkg::CMD_NONE;
    out_d.pump_request         = 1'b0;
    out_d.slice_state          = phase_d;
    out_d.dwell_timed_out      = 1'b0;
    out_d.overhead_estimate_ms = ovh_d;
    unique case (phase_q)
      rtss_pkg::PH_SCAN: begin
        if (scan_stay) begin
          out_d.pump_request = 1'b1;
          out_d.next_wait_ms = PumpWait;
        end else begin
          out_d.radio_command = rtss_pkg::CMD_LEAVE;
        end
      end
      rtss_pkg::PH_DWELL: begin
        out_d.pump_request = 1'b1;
        if (dwell_stay) begin
          out_d.next_wait_ms = PumpWait;
        end else begin
          out_d.radio_command   = rtss_pkg::CMD_LEAVE;
          out_d.dwell_timed_out = dwell_to;
        end
      end
      default: begin
        priority if (host_hold) begin
          out_d.next_wait_ms = hold - held[15:0];
        end else if (host_tx_yield || host_busy_wait) begin
          out_d.next_wait_ms = retry_q;
        end else if (host_enter) begin
          out_d.radio_command = rtss_pkg::CMD_ENTER;
          out_d.next_wait_ms  = dwell_q;
        end else begin
          out_d.next_wait_ms = hold;
        end
      end
    endcase
  end

  // Configuration writes
  logic cfg_we, cfg_rederive;
  assign cfg_we = cfg_i.valid && cfg_i.ready;
  always_comb begin
    unique case (cfg_i.index)
      rtss_pkg::CFG_HOLD_OVR, rtss_pkg::CFG_HOLD_FLOOR, rtss_pkg::CFG_BLIND_BUDGET,
      rtss_pkg::CFG_DWELL, rtss_pkg::CFG_MAX_DWELL, rtss_pkg::CFG_TX_YIELD,
      rtss_pkg::CFG_RETRY: cfg_rederive = cfg_we;
      default:             cfg_rederive = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q      <= 1'b0;
      hold_ovr_q     <= 16'd0;
      hold_floor_q   <= 16'd20;
      blind_budget_q <= 16'd0;
      dwell_q        <= 16'd20;
      max_dwell_q    <= 16'd0;
      tx_yield_q     <= 13'd1000;
      retry_q        <= 16'd0;
    end else if (cfg_we) begin
      unique case (cfg_i.index)
        rtss_pkg::CFG_ENABLED:      enabled_q      <= cfg_i.wdata[0];
        rtss_pkg::CFG_HOLD_OVR:     hold_ovr_q     <= cfg_i.wdata;
        rtss_pkg::CFG_HOLD_FLOOR:   hold_floor_q   <= cfg_i.wdata;
        rtss_pkg::CFG_BLIND_BUDGET: blind_budget_q <= cfg_i.wdata;
        rtss_pkg::CFG_DWELL:        dwell_q        <= cfg_i.wdata;
        rtss_pkg::CFG_MAX_DWELL:    max_dwell_q    <= cfg_i.wdata;
        rtss_pkg::CFG_TX_YIELD:     tx_yield_q     <= cfg_i.wdata[12:0];
        rtss_pkg::CFG_RETRY:        retry_q        <= cfg_i.wdata;
        default: ;
      endcase
    end
  end

  // Scheduler state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= rtss_pkg::PH_HOST;
      started_q       <= 1'b0;
      phase_entered_q <= 32'd0;
      yield_waiting_q <= 1'b0;
      yield_started_q <= 32'd0;
      dwell_started_q <= 32'd0;
      cycle_ext_q     <= 1'b0;
      slice_seen_q    <= 1'b0;
      last_slice_q    <= 32'd0;
      ovh_q           <= 9'd0;
      derived_q       <= 9'd0;
    end else if (adv) begin
      phase_q         <= phase_d;
      started_q       <= 1'b1;
      phase_entered_q <= phase_entered_d;
      yield_waiting_q <= yield_waiting_d;
      yield_started_q <= yield_started_d;
      dwell_started_q <= dwell_started_d;
      cycle_ext_q     <= cycle_ext_d;
      slice_seen_q    <= slice_seen_d;
      last_slice_q    <= last_slice_d;
      ovh_q           <= ovh_d;
      derived_q       <= derived_d;
    end else if (cfg_rederive) begin
      derived_q <= ovh_q;
    end
  end

  // Pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) in_valid_q <= in_i.valid;
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Pipeline payload
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) in_q <= in_i.data;
    if (adv) out_q <= out_d;
  end

endmodule
